// ===== rtl/compass_heading_atan2_assert.svh =====
// Assertion macros for the compass heading top level.
`ifndef COMPASS_HEADING_ATAN2_ASSERT_SVH
`define COMPASS_HEADING_ATAN2_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define CAH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define CAH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CAH_ASSERT_IMP(lbl, ante, cons, msg)
`define CAH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/cah_pkg.sv =====
// Shared constants, types and the arctangent table of the compass heading block.
package cah_pkg;

	localparam int INPUT_BITS   = 20;
	localparam int ANGLE_BITS   = 16;
	localparam int HEADING_W    = 16;
	localparam int TURN_LOG     = 32;
	localparam int CORDIC_ITERS = 30;
	localparam int ITER_W       = $clog2(CORDIC_ITERS);

	// Magnitudes are normalized until the larger one has its top bit here.
	localparam int NORM_TOP = 30;
	localparam int NW       = NORM_TOP + 1;
	localparam int MSB_W    = $clog2(INPUT_BITS);
	localparam int SH_W     = $clog2(NORM_TOP + 1);

	// Datapath widths; the CORDIC gain keeps x and y below 2^33.
	localparam int CW    = NW + 4;
	localparam int ZW    = TURN_LOG + 2;
	localparam int TAB_W = 30;
	localparam int T_W   = TURN_LOG - 1;

	localparam logic [ANGLE_BITS-1:0] QUARTER_ANGLE = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] HALF_ANGLE    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [ANGLE_BITS-1:0] THREEQ_ANGLE  = QUARTER_ANGLE + HALF_ANGLE;

	localparam logic [TURN_LOG-1:0] HALF_TURN  = TURN_LOG'(1) << (TURN_LOG - 1);
	localparam logic [TURN_LOG-1:0] ROUND_HALF = TURN_LOG'(1) << (TURN_LOG - ANGLE_BITS - 1);
	localparam logic [T_W-1:0]      T_MAX      = T_W'(1) << (TURN_LOG - 2);

	// atan(2^-i) in units of 2^-32 turn.
	localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
		30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
		30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
	};

	// Sideband that travels with each item along the chain.
	typedef struct packed {
		logic                  x_neg;
		logic                  y_neg;
		logic                  special;
		logic [ANGLE_BITS-1:0] spec_angle;
	} cah_tag_t;

	function automatic logic signed [ZW-1:0] atan_step(input logic [ITER_W-1:0] idx);
		logic [TAB_W-1:0] v;
		v = ATAN_TAB[idx];
		return $signed({{(ZW - TAB_W){1'b0}}, v});
	endfunction

endpackage

// ===== rtl/cah_mag_if.sv =====
// Input channel: one magnetometer sample with valid/ready handshake.
interface cah_mag_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cah_pkg::INPUT_BITS-1:0] mag_x;
	logic signed [cah_pkg::INPUT_BITS-1:0] mag_y;

	modport source (output valid, output mag_x, output mag_y, input ready);
	modport sink (input valid, input mag_x, input mag_y, output ready);
endinterface

// ===== rtl/cah_hdg_if.sv =====
// Output channel: one heading angle with valid/ready handshake.
interface cah_hdg_if;
	logic                           valid;
	logic                           ready;
	logic [cah_pkg::HEADING_W-1:0]  heading;

	modport source (output valid, output heading, input ready);
	modport sink (input valid, input heading, output ready);
endinterface

// ===== rtl/cah_norm.sv =====
// Front end: magnitudes, special cases and normalization ahead of the CORDIC chain.
module cah_norm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [cah_pkg::INPUT_BITS-1:0]  mag_x,
	input  logic signed [cah_pkg::INPUT_BITS-1:0]  mag_y,
	output logic                                   out_valid,
	output cah_pkg::cah_tag_t                      out_tag,
	output logic signed [cah_pkg::CW-1:0]          out_cx,
	output logic signed [cah_pkg::CW-1:0]          out_cy
);

	logic                               x_neg, y_neg, x_zero, y_zero;
	logic [cah_pkg::INPUT_BITS-1:0]     ax, ay;
	cah_pkg::cah_tag_t                  tag_d;

	logic                               valid_s1, valid_s2, valid_s3;
	cah_pkg::cah_tag_t                  tag_s1, tag_s2, tag_s3;
	logic [cah_pkg::INPUT_BITS-1:0]     ax_s1, ay_s1, ax_s2, ay_s2;
	logic [cah_pkg::MSB_W-1:0]          msb;
	logic [cah_pkg::SH_W-1:0]           sh_d, sh_s2;
	logic [cah_pkg::NW-1:0]             nx_s3, ny_s3;
	logic [cah_pkg::INPUT_BITS-1:0]     or_mag;

	always_comb begin
		x_neg  = mag_x[cah_pkg::INPUT_BITS-1];
		y_neg  = mag_y[cah_pkg::INPUT_BITS-1];
		x_zero = (mag_x == '0);
		y_zero = (mag_y == '0);
		ax     = x_neg ? (~mag_x + 1'b1) : mag_x;
		ay     = y_neg ? (~mag_y + 1'b1) : mag_y;

		tag_d.x_neg   = x_neg;
		tag_d.y_neg   = y_neg;
		tag_d.special = x_zero || y_zero;
		// Zero x gives QUARTER for y > 0, else THREEQ; zero y takes its side from x's sign.
		if (x_zero) begin
			tag_d.spec_angle = (!y_neg && !y_zero) ? cah_pkg::QUARTER_ANGLE
			                                        : cah_pkg::THREEQ_ANGLE;
		end else begin
			tag_d.spec_angle = x_neg ? cah_pkg::HALF_ANGLE : '0;
		end
	end

	// The top bit of the larger magnitude is the top bit of the OR of both.
	always_comb begin
		or_mag = ax_s1 | ay_s1;
		msb    = '0;
		for (int i = 0; i < cah_pkg::INPUT_BITS; i++) begin
			if (or_mag[i]) begin
				msb = cah_pkg::MSB_W'(i);
			end
		end
		sh_d = cah_pkg::SH_W'(cah_pkg::NORM_TOP) - cah_pkg::SH_W'(msb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_d;
			ax_s1  <= ax;
			ay_s1  <= ay;
			tag_s2 <= tag_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sh_s2  <= sh_d;
			tag_s3 <= tag_s2;
			nx_s3  <= cah_pkg::NW'(ax_s2) << sh_s2;
			ny_s3  <= cah_pkg::NW'(ay_s2) << sh_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_tag   = tag_s3;
	assign out_cx    = $signed({{(cah_pkg::CW - cah_pkg::NW){1'b0}}, nx_s3});
	assign out_cy    = $signed({{(cah_pkg::CW - cah_pkg::NW){1'b0}}, ny_s3});

endmodule

// ===== rtl/cah_cell.sv =====
// One vectoring CORDIC iteration with its pipeline register.
module cah_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [cah_pkg::ITER_W-1:0]        iter,
	input  logic                              in_valid,
	input  cah_pkg::cah_tag_t                 in_tag,
	input  logic signed [cah_pkg::CW-1:0]     in_cx,
	input  logic signed [cah_pkg::CW-1:0]     in_cy,
	input  logic signed [cah_pkg::ZW-1:0]     in_z,
	output logic                              out_valid,
	output cah_pkg::cah_tag_t                 out_tag,
	output logic signed [cah_pkg::CW-1:0]     out_cx,
	output logic signed [cah_pkg::CW-1:0]     out_cy,
	output logic signed [cah_pkg::ZW-1:0]     out_z
);

	logic signed [cah_pkg::CW-1:0] dx, dy, cx_d, cy_d;
	logic signed [cah_pkg::ZW-1:0] step, z_d;
	logic                          valid_s1;
	cah_pkg::cah_tag_t             tag_s1;
	logic signed [cah_pkg::CW-1:0] cx_s1, cy_s1;
	logic signed [cah_pkg::ZW-1:0] z_s1;

	// Arithmetic shifts round toward minus infinity, as the iteration requires.
	always_comb begin
		dx   = in_cy >>> iter;
		dy   = in_cx >>> iter;
		step = cah_pkg::atan_step(iter);
		if (!in_cy[cah_pkg::CW-1]) begin
			cx_d = in_cx + dx;
			cy_d = in_cy - dy;
			z_d  = in_z + step;
		end else begin
			cx_d = in_cx - dx;
			cy_d = in_cy + dy;
			z_d  = in_z - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			cx_s1  <= cx_d;
			cy_s1  <= cy_d;
			z_s1   <= z_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_tag   = tag_s1;
	assign out_cx    = cx_s1;
	assign out_cy    = cy_s1;
	assign out_z     = z_s1;

endmodule

// ===== rtl/cah_fin.sv =====
// Back end: clamp, quadrant placement, rounding and the output register.
module cah_fin (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  cah_pkg::cah_tag_t                 in_tag,
	input  logic signed [cah_pkg::ZW-1:0]     in_z,
	output logic                              out_valid,
	output logic [cah_pkg::HEADING_W-1:0]     out_heading
);

	logic [cah_pkg::T_W-1:0]        t;
	logic [cah_pkg::TURN_LOG-1:0]   t32, a, r;
	logic [cah_pkg::ANGLE_BITS-1:0] angle;
	logic                           valid_s1;
	logic [cah_pkg::HEADING_W-1:0]  heading_s1;

	always_comb begin
		if (in_z[cah_pkg::ZW-1]) begin
			t = '0;
		end else if (in_z > $signed({{(cah_pkg::ZW - cah_pkg::T_W){1'b0}}, cah_pkg::T_MAX})) begin
			t = cah_pkg::T_MAX;
		end else begin
			t = in_z[cah_pkg::T_W-1:0];
		end
		t32 = cah_pkg::TURN_LOG'(t);

		case ({in_tag.x_neg, in_tag.y_neg})
			2'b00:   a = t32;
			2'b10:   a = cah_pkg::HALF_TURN - t32;
			2'b11:   a = cah_pkg::HALF_TURN + t32;
			default: a = '0 - t32;
		endcase

		// A carry out of the top bit is a full turn and wraps to zero.
		r = a + cah_pkg::ROUND_HALF;
		angle = in_tag.special ? in_tag.spec_angle
		                       : r[cah_pkg::TURN_LOG-1 -: cah_pkg::ANGLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading_s1 <= cah_pkg::HEADING_W'(angle);
		end
	end

	assign out_valid   = valid_s1;
	assign out_heading = heading_s1;

endmodule

// ===== rtl/compass_heading_atan2.sv =====
// Top level of the compass heading block: front end, CORDIC chain and output stage.
`include "compass_heading_atan2_assert.svh"

// Heading from one magnetometer sample (signed x, y) as an unsigned binary angle, where
// 2^16 is a full turn, rounded to the nearest step. The block takes one item every clock
// while the output is not stalled and holds up to 34 items in flight: three front-end
// stages (magnitudes and axis cases, leading-one search, normalizing shift), one stage
// per CORDIC cell for 30 iterations, and the output register. All stages move together;
// when a finished heading is not taken, the whole chain holds and mag.ready drops in the
// same cycle.
module compass_heading_atan2 (
	input  logic          clk,
	input  logic          arst_n,
	cah_mag_if.sink       mag,
	cah_hdg_if.source     hdg
);

	localparam int N = cah_pkg::CORDIC_ITERS;

	logic                          en;
	logic                          valid_c [N+1];
	cah_pkg::cah_tag_t             tag_c   [N+1];
	logic signed [cah_pkg::CW-1:0] cx_c    [N+1];
	logic signed [cah_pkg::CW-1:0] cy_c    [N+1];
	logic signed [cah_pkg::ZW-1:0] z_c     [N+1];

	assign en        = !hdg.valid || hdg.ready;
	assign mag.ready = en;

	cah_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mag.valid),
		.mag_x     (mag.mag_x),
		.mag_y     (mag.mag_y),
		.out_valid (valid_c[0]),
		.out_tag   (tag_c[0]),
		.out_cx    (cx_c[0]),
		.out_cy    (cy_c[0])
	);

	assign z_c[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		cah_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.iter      (cah_pkg::ITER_W'(k)),
			.in_valid  (valid_c[k]),
			.in_tag    (tag_c[k]),
			.in_cx     (cx_c[k]),
			.in_cy     (cy_c[k]),
			.in_z      (z_c[k]),
			.out_valid (valid_c[k+1]),
			.out_tag   (tag_c[k+1]),
			.out_cx    (cx_c[k+1]),
			.out_cy    (cy_c[k+1]),
			.out_z     (z_c[k+1])
		);
	end

	cah_fin u_fin (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (valid_c[N]),
		.in_tag      (tag_c[N]),
		.in_z        (z_c[N]),
		.out_valid   (hdg.valid),
		.out_heading (hdg.heading)
	);

	`CAH_ASSERT_IMP(a_stall_blocks_input, hdg.valid && !hdg.ready, !mag.ready, "input taken while output stalled")
	`CAH_ASSERT_IMP(a_empty_output_ready, !hdg.valid, mag.ready, "input refused with empty output")
	`CAH_ASSERT_NEXT(a_first_cell_advance, en && valid_c[0], valid_c[1], "item lost entering the chain")
	`CAH_ASSERT_NEXT(a_special_carried, en && valid_c[0] && tag_c[0].special, tag_c[1].special, "axis case flag lost in the chain")

endmodule
